// ===== rtl/bba_pkg.sv =====
// ============================================================================
// bba_pkg
// Shared types and constants of the block bitmap allocator.
// ============================================================================
`default_nettype none

package bba_pkg;

    localparam int CFG_W     = 17;
    localparam int BN_W      = 16;
    localparam int REG_IDX_W = 1;

    localparam logic [CFG_W-1:0]     COUNT_MAX    = '1;
    localparam logic [CFG_W-1:0]     TOTAL_RESET  = 17'h10000;
    localparam logic [REG_IDX_W-1:0] REG_TOTAL    = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_RESERVED = 1'b1;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_SET   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_ALLOC = 3'd3,
        OP_INIT  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]      op;
        logic [BN_W-1:0] block_number;
    } t_bba_req;

    typedef struct packed {
        logic [1:0]       status;
        logic             bit_value;
        logic [BN_W-1:0]  allocated_block;
        logic [CFG_W-1:0] free_blocks;
    } t_bba_rsp;

endpackage

`default_nettype wire

// ===== rtl/bba_map_ram.sv =====
// ============================================================================
// bba_map_ram
// Usage map storage: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module bba_map_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int AW    = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bba_zero_find.sv =====
// ============================================================================
// bba_zero_find
// Index of the lowest clear bit of a map word, by binary search over halves.
// ============================================================================
`default_nettype none

module bba_zero_find #(
    parameter int WORD_BITS = 32,
    parameter int KW        = 5
) (
    input  wire logic [WORD_BITS-1:0] i_word,
    output logic      [KW-1:0]        o_idx
);

    localparam int PADW = 1 << KW;

    always_comb begin
        logic [PADW-1:0] v;
        logic [PADW-1:0] m;
        logic [KW-1:0]   idx;
        v = '1;
        v[WORD_BITS-1:0] = i_word;
        idx = '0;
        for (int s = KW - 1; s >= 0; s--) begin
            m = ~({PADW{1'b1}} << (1 << s));
            if ((v & m) == m) begin
                v   = v >> (1 << s);
                idx = idx | (KW'(1) << s);
            end
        end
        o_idx = idx;
    end

endmodule

`default_nettype wire

// ===== rtl/block_bitmap_allocator_unit.sv =====
// ============================================================================
// block_bitmap_allocator_unit
// Used/free bitmap over storage blocks with a free count and first-fit alloc.
// ============================================================================
// Request channel: i_req (op, block_number) is taken when start is high and
// busy is low. One response per request appears on o_rsp for exactly one
// cycle with o_done high; the receiver cannot stall it.
// Config: i_cfg_we writes register i_cfg_idx (0 total, 1 reserved) at once;
// write only while busy is low.
// Steps from acceptance to o_done:
//   read / mark used / mark free: decode, map read, update (an
//     out-of-range block is answered from decode); init: decode, then every
//     map word written, one map word written per cycle. allocate: decode,
//     then a scan of map words, one per cycle through the map read port,
//     from the lowest word that may hold a clear bit, then pick and commit;
//     refused after the scan when no word read has a clear bit, or from decode when the free count is zero.
// Reset: a clearing pass writes every map word (2048 at the defaults)
// with busy high; config writes are still taken meanwhile.
// ============================================================================
`default_nettype none

module block_bitmap_allocator_unit #(
    parameter int MAX_BLOCKS = 65536,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire bba_pkg::t_bba_req                 i_req,
    output logic                                   o_done,
    output bba_pkg::t_bba_rsp                      o_rsp,
    input  wire logic                              i_cfg_we,
    input  wire logic [bba_pkg::REG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bba_pkg::CFG_W-1:0]         i_cfg_wdata
);

    import bba_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC_W      = $clog2(MAP_WORDS + 1);
    localparam int TW        = ($clog2(MAX_BLOCKS + WORD_BITS) > CFG_W) ?
                               $clog2(MAX_BLOCKS + WORD_BITS) : CFG_W;
    localparam int KW        = $clog2(WORD_BITS);
    localparam int SH        = BN_W + KW;
    localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW        = BN_W + SH + 1;
    localparam int QW        = (WA_W > BN_W) ? WA_W : BN_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_ADDR   = 8'b0000_0100,
        S_MOD    = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_PICK   = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_FILL   = 8'b1000_0000
    } t_state;

    t_state                 r_state, n_state;
    t_bba_req               r_req;
    logic [CFG_W-1:0]       r_total, n_total;
    logic [CFG_W-1:0]       r_reserved, n_reserved;
    logic [CFG_W-1:0]       r_count, n_count;
    logic [WC_W-1:0]        r_hint, n_hint;
    logic [TW-1:0]          r_hint_base, n_hint_base;
    logic [WC_W-1:0]        r_iss_w, n_iss_w;
    logic [TW-1:0]          r_iss_base, n_iss_base;
    logic                   r_pend, n_pend;
    logic [TW-1:0]          r_fill_lim, n_fill_lim;
    logic                   r_fill_rsp, n_fill_rsp;
    logic                   r_done, n_done;
    t_bba_rsp               r_rsp, n_rsp;

    logic [WA_W-1:0]        r_q, n_q;
    logic [KW-1:0]          r_rem, n_rem;
    logic [WA_W-1:0]        r_pend_w, n_pend_w;
    logic [TW-1:0]          r_pend_base, n_pend_base;
    logic [WA_W-1:0]        r_cand_w, n_cand_w;
    logic [TW-1:0]          r_cand_base, n_cand_base;
    logic [WORD_BITS-1:0]   r_word, n_word;
    logic [TW-1:0]          r_pick, n_pick;
    logic [KW-1:0]          r_k, n_k;

    logic                   mem_we;
    logic [WA_W-1:0]        mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic                   mem_re;
    logic [WA_W-1:0]        mem_raddr;
    logic [WORD_BITS-1:0]   mem_rdata;
    logic [KW-1:0]          fz_idx;

    logic [TW-1:0]          eff_total;
    logic [TW-1:0]          eff_res;
    logic [TW-1:0]          bn_ext;
    logic [PW-1:0]          prod;
    logic [QW-1:0]          q_ext;
    logic [TW-1:0]          rem_full;
    logic [TW-1:0]          fill_diff;

    bba_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bba_zero_find #(
        .WORD_BITS (WORD_BITS),
        .KW        (KW)
    ) u_zero_find (
        .i_word (r_word),
        .o_idx  (fz_idx)
    );

    assign eff_total = (TW'(r_total) > TW'(MAX_BLOCKS)) ? TW'(MAX_BLOCKS) : TW'(r_total);
    assign eff_res   = (TW'(r_reserved) > eff_total) ? eff_total : TW'(r_reserved);
    assign bn_ext    = TW'(r_req.block_number);
    assign prod      = PW'(r_req.block_number) * PW'(RECIP);
    assign q_ext     = QW'(prod >> SH);
    assign rem_full  = bn_ext - TW'(TW'(r_q) * TW'(WORD_BITS));
    assign fill_diff = r_fill_lim - r_iss_base;

    always_comb begin
        logic                 old_bit;
        logic [WORD_BITS-1:0] bit_mask;
        logic                 can_issue;

        n_state     = r_state;
        n_total     = r_total;
        n_reserved  = r_reserved;
        n_count     = r_count;
        n_hint      = r_hint;
        n_hint_base = r_hint_base;
        n_iss_w     = r_iss_w;
        n_iss_base  = r_iss_base;
        n_pend      = r_pend;
        n_fill_lim  = r_fill_lim;
        n_fill_rsp  = r_fill_rsp;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        n_q         = r_q;
        n_rem       = r_rem;
        n_pend_w    = r_pend_w;
        n_pend_base = r_pend_base;
        n_cand_w    = r_cand_w;
        n_cand_base = r_cand_base;
        n_word      = r_word;
        n_pick      = r_pick;
        n_k         = r_k;

        mem_we    = 1'b0;
        mem_waddr = r_iss_w[WA_W-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_q;

        old_bit   = mem_rdata[r_rem];
        bit_mask  = WORD_BITS'(1) << r_rem;
        can_issue = (r_iss_w < WC_W'(MAP_WORDS)) && (r_iss_base < eff_total);

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TOTAL:    n_total    = i_cfg_wdata;
                REG_RESERVED: n_reserved = i_cfg_wdata;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_rsp.status          = ST_OK;
                n_rsp.bit_value       = 1'b0;
                n_rsp.allocated_block = '0;
                n_rsp.free_blocks     = r_count;
                case (r_req.op)
                    OP_READ, OP_SET, OP_CLEAR: begin
                        if (bn_ext >= eff_total) begin
                            n_rsp.status = ST_RANGE;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_q     = q_ext[WA_W-1:0];
                            n_state = S_ADDR;
                        end
                    end
                    OP_ALLOC: begin
                        if (r_count == '0) begin
                            n_rsp.status = ST_NOFREE;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_iss_w    = r_hint;
                            n_iss_base = r_hint_base;
                            n_pend     = 1'b0;
                            n_state    = S_SCAN;
                        end
                    end
                    OP_INIT: begin
                        n_fill_lim        = eff_res;
                        n_count           = CFG_W'(eff_total - eff_res);
                        n_rsp.free_blocks = n_count;
                        n_iss_w           = '0;
                        n_iss_base        = '0;
                        n_fill_rsp        = 1'b1;
                        n_state           = S_FILL;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_ADDR: begin
                mem_re    = 1'b1;
                mem_raddr = r_q;
                n_rem     = rem_full[KW-1:0];
                n_state   = S_MOD;
            end

            S_MOD: begin
                mem_waddr       = r_q;
                n_rsp.bit_value = old_bit;
                case (r_req.op)
                    OP_SET: begin
                        mem_we          = 1'b1;
                        mem_wdata       = mem_rdata | bit_mask;
                        n_rsp.bit_value = 1'b1;
                        if (!old_bit && r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        mem_we          = 1'b1;
                        mem_wdata       = mem_rdata & ~bit_mask;
                        n_rsp.bit_value = 1'b0;
                        if (old_bit && r_count != COUNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                        if (WC_W'(r_q) < r_hint) begin
                            n_hint      = WC_W'(r_q);
                            n_hint_base = bn_ext - TW'(r_rem);
                        end
                    end
                    default: begin
                    end
                endcase
                n_rsp.free_blocks = n_count;
                n_done            = 1'b1;
                n_state           = S_IDLE;
            end

            S_SCAN: begin
                mem_raddr = r_iss_w[WA_W-1:0];
                if (r_pend && !(&mem_rdata)) begin
                    n_word      = mem_rdata;
                    n_cand_w    = r_pend_w;
                    n_cand_base = r_pend_base;
                    n_pend      = 1'b0;
                    n_state     = S_PICK;
                end else if (can_issue) begin
                    mem_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_w    = r_iss_w[WA_W-1:0];
                    n_pend_base = r_iss_base;
                    n_iss_w     = r_iss_w + 1'b1;
                    n_iss_base  = r_iss_base + TW'(WORD_BITS);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_hint       = r_iss_w;
                        n_hint_base  = r_iss_base;
                        n_rsp.status = ST_NOFREE;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_PICK: begin
                n_k     = fz_idx;
                n_pick  = r_cand_base + TW'(fz_idx);
                n_state = S_COMMIT;
            end

            S_COMMIT: begin
                n_hint      = WC_W'(r_cand_w);
                n_hint_base = r_cand_base;
                if (r_pick < eff_total) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cand_w;
                    mem_wdata = r_word | (WORD_BITS'(1) << r_k);
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_rsp.bit_value       = 1'b1;
                    n_rsp.allocated_block = r_pick[BN_W-1:0];
                end else begin
                    n_rsp.status = ST_NOFREE;
                end
                n_rsp.free_blocks = n_count;
                n_done            = 1'b1;
                n_state           = S_IDLE;
            end

            S_FILL: begin
                mem_we = 1'b1;
                if (r_fill_lim >= r_iss_base + TW'(WORD_BITS)) begin
                    mem_wdata = '1;
                end else if (r_fill_lim > r_iss_base) begin
                    mem_wdata = ~({WORD_BITS{1'b1}} << fill_diff[KW-1:0]);
                end
                n_iss_w    = r_iss_w + 1'b1;
                n_iss_base = r_iss_base + TW'(WORD_BITS);
                if (r_iss_w == WC_W'(MAP_WORDS - 1)) begin
                    n_hint      = '0;
                    n_hint_base = '0;
                    n_fill_rsp  = 1'b0;
                    n_done      = r_fill_rsp;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_total     <= TOTAL_RESET;
            r_reserved  <= '0;
            r_count     <= '0;
            r_hint      <= '0;
            r_hint_base <= '0;
            r_iss_w     <= '0;
            r_iss_base  <= '0;
            r_pend      <= 1'b0;
            r_fill_lim  <= '0;
            r_fill_rsp  <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_reserved  <= n_reserved;
            r_count     <= n_count;
            r_hint      <= n_hint;
            r_hint_base <= n_hint_base;
            r_iss_w     <= n_iss_w;
            r_iss_base  <= n_iss_base;
            r_pend      <= n_pend;
            r_fill_lim  <= n_fill_lim;
            r_fill_rsp  <= n_fill_rsp;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_rsp       <= n_rsp;
        r_q         <= n_q;
        r_rem       <= n_rem;
        r_pend_w    <= n_pend_w;
        r_pend_base <= n_pend_base;
        r_cand_w    <= n_cand_w;
        r_cand_base <= n_cand_base;
        r_word      <= n_word;
        r_pick      <= n_pick;
        r_k         <= n_k;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response while a request is still in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two responses in consecutive cycles");

    a_err_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |->
            (o_rsp.allocated_block == '0 && o_rsp.bit_value == 1'b0))
        else $error("error response carries a block or bit");

endmodule

`default_nettype wire

// ===== verif/block_bitmap_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// block_bitmap_allocator_unit_tb
// Self-checking bench for the block bitmap allocator: a directed pass over
// the corner cases, then eight configuration phases of random requests with
// sender idling, checked request by request against a bitmap scoreboard.
// ============================================================================

module block_bitmap_allocator_unit_tb;

    import bba_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_BLK        = 65536;
    localparam int WORD_W         = 32;
    localparam int MAP_WORDS      = MAX_BLK / WORD_W;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int N_PHASES       = 8;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // ------------------------------------------------------------------------
    // Scoreboard: bitmap, free count and registers, plus expected responses
    // ------------------------------------------------------------------------
    class bitmap_scoreboard;
        bit [WORD_W-1:0] usage_words [MAP_WORDS];
        bit [CFG_W-1:0]  free_cnt;
        bit [CFG_W-1:0]  total_reg;
        bit [CFG_W-1:0]  reserved_reg;
        t_bba_rsp        expected_rsps [$];
        int              errors;
        int              n_reqs;
        int              n_alloc;
        int              n_denied;
        int              n_range;
        int              n_init;

        function new();
            total_reg = TOTAL_RESET;
        endfunction

        function void take_block(int unsigned b);
            if (!usage_words[b / WORD_W][b % WORD_W]) begin
                usage_words[b / WORD_W][b % WORD_W] = 1'b1;
                if (free_cnt != 0)
                    free_cnt--;
            end
        endfunction

        function void note_request(t_bba_req req);
            t_bba_rsp       rsp;
            bit [CFG_W-1:0] lim;
            bit [CFG_W-1:0] res;
            int unsigned    bn;
            int unsigned    w;
            int unsigned    k;
            int unsigned    pick;
            bit             found;
            rsp   = '0;
            found = 1'b0;
            pick  = 0;
            bn    = req.block_number;
            lim   = (total_reg > TOTAL_RESET) ? TOTAL_RESET : total_reg;
            n_reqs++;
            case (req.op)
                OP_READ, OP_SET, OP_CLEAR: begin
                    if (bn >= lim) begin
                        rsp.status = ST_RANGE;
                        n_range++;
                    end else begin
                        if (req.op == OP_SET) begin
                            take_block(bn);
                        end else if (req.op == OP_CLEAR
                                     && usage_words[bn / WORD_W][bn % WORD_W]) begin
                            usage_words[bn / WORD_W][bn % WORD_W] = 1'b0;
                            if (free_cnt != COUNT_MAX)
                                free_cnt++;
                        end
                        rsp.bit_value = usage_words[bn / WORD_W][bn % WORD_W];
                    end
                end
                OP_ALLOC: begin
                    n_alloc++;
                    if (free_cnt != 0) begin
                        w = 0;
                        while (w < MAP_WORDS && w * WORD_W < lim && usage_words[w] == '1)
                            w++;
                        if (w < MAP_WORDS && w * WORD_W < lim) begin
                            k = 0;
                            while (usage_words[w][k])
                                k++;
                            pick  = w * WORD_W + k;
                            found = (pick < lim);
                        end
                    end
                    if (found) begin
                        take_block(pick);
                        rsp.allocated_block = pick[BN_W-1:0];
                        rsp.bit_value       = 1'b1;
                    end else begin
                        rsp.status = ST_NOFREE;
                        n_denied++;
                    end
                end
                OP_INIT: begin
                    n_init++;
                    res = (reserved_reg > lim) ? lim : reserved_reg;
                    foreach (usage_words[i])
                        usage_words[i] = '0;
                    for (int unsigned b = 0; b < res; b++)
                        usage_words[b / WORD_W][b % WORD_W] = 1'b1;
                    free_cnt = lim - res;
                end
                default: ;
            endcase
            rsp.free_blocks = free_cnt;
            expected_rsps.push_back(rsp);
        endfunction

        function void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
            if (want_v !== got_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_response(t_bba_rsp got);
            t_bba_rsp want;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_rsps.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("bit_value", want.bit_value, got.bit_value);
            compare_field("allocated_block", want.allocated_block, got.allocated_block);
            compare_field("free_blocks", want.free_blocks, got.free_blocks);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clocking
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_bba_req             i_req       = '0;
    logic                 o_done;
    t_bba_rsp             o_rsp;
    logic                 i_cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    bitmap_scoreboard sb;
    int               idle_pct;
    int               idle_cycles = 0;

    logic [CFG_W-1:0] phase_total    [N_PHASES] = '{17'd200, 17'h1FFFF, 17'd33, 17'd0,
                                                    17'h10000, 17'd1, 17'd1000, 17'd0};
    logic [CFG_W-1:0] phase_reserved [N_PHASES] = '{17'd16, 17'd65000, 17'd40, 17'd0,
                                                    17'd0, 17'd0, 17'd1, 17'd0};
    int               phase_idle     [N_PHASES] = '{0, 55, 0, 15, 0, 55, 0, 15};
    int               phase_items    [N_PHASES] = '{150, 150, 150, 40, 200, 100, 180, 180};

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    block_bitmap_allocator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_response(o_rsp);
    end

    // stall watchdog: cycles with neither a request taken nor a response out
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic issue(input logic [2:0] op, input logic [BN_W-1:0] bn);
        t_bba_req req;
        req.op           = op;
        req.block_number = bn;
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_request(req);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_rsps.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] reserved);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_TOTAL;
        i_cfg_wdata <= total;
        @(posedge i_clk);
        sb.total_reg = total;
        i_cfg_idx   <= REG_RESERVED;
        i_cfg_wdata <= reserved;
        @(posedge i_clk);
        sb.reserved_reg = reserved;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [BN_W-1:0] pick_block(input int unsigned lim);
        int unsigned r;
        r = $urandom_range(99);
        if (lim != 0 && r < 70)
            return BN_W'($urandom_range(lim - 1));
        if (lim < MAX_BLK && r < 85)
            return BN_W'($urandom_range(MAX_BLK - 1, lim));
        return BN_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] total;
        logic [CFG_W-1:0] reserved;
        logic [2:0]       op;
        int unsigned      lim;
        int unsigned      r;
        sb       = new();
        idle_pct = 0;
        repeat (RESET_CYCLES)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: count is zero although every bit is clear
        issue(OP_ALLOC, '0);
        issue(OP_READ, '0);
        issue(OP_SET, 16'hFFFF);
        issue(OP_CLEAR, 16'hFFFF);
        issue(OP_ALLOC, '0);
        issue(OP_UNUSED_LO, 16'hFFFF);
        issue(OP_UNUSED_HI, '0);

        // oversized total
        set_regs(17'h1FFFF, 17'd3);
        issue(OP_INIT, 16'h5A5A);
        issue(OP_ALLOC, '0);
        issue(OP_SET, 16'hFFFF);
        issue(OP_CLEAR, 16'd2);
        issue(OP_ALLOC, '0);

        // oversized reserve
        set_regs(17'd40, 17'h1FFFF);
        issue(OP_INIT, '0);
        issue(OP_CLEAR, 16'd39);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_READ, 16'd40);
        issue(OP_SET, 16'd40);
        issue(OP_CLEAR, 16'hFFFF);

        // zero total
        set_regs(17'd0, 17'd0);
        issue(OP_INIT, '0);
        issue(OP_ALLOC, '0);
        issue(OP_READ, '0);

        // count nonzero, first clear bit lies at the total
        set_regs(TOTAL_RESET, 17'd40);
        issue(OP_INIT, '0);
        set_regs(17'd40, 17'd40);
        issue(OP_ALLOC, '0);

        for (int p = 0; p < N_PHASES; p++) begin
            total    = phase_total[p];
            reserved = phase_reserved[p];
            if (p == N_PHASES - 1) begin
                total    = CFG_W'($urandom_range(4096, 1));
                reserved = CFG_W'($urandom_range(total + 8, 0));
            end
            set_regs(total, reserved);
            idle_pct = phase_idle[p];
            lim      = (total > TOTAL_RESET) ? TOTAL_RESET : total;
            issue(OP_INIT, BN_W'($urandom));
            for (int n = 0; n < phase_items[p]; n++) begin
                if (n == phase_items[p] / 2)
                    wait_idle();
                r = $urandom_range(99);
                if (r < 2)
                    op = OP_INIT;
                else if (r < 5)
                    op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
                else if (r < 20)
                    op = OP_READ;
                else if (r < 35)
                    op = OP_SET;
                else if (r < 60)
                    op = OP_CLEAR;
                else
                    op = OP_ALLOC;
                issue(op, pick_block(lim));
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);

        $display("Ran %0d requests over %0d register settings: %0d inits, %0d out of range.",
                 sb.n_reqs, N_PHASES + 5, sb.n_init, sb.n_range);
        $display("Allocations: %0d attempted, %0d refused for lack of a free block.",
                 sb.n_alloc, sb.n_denied);
        if (sb.errors == 0 && sb.expected_rsps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d responses missing", sb.errors,
                     sb.expected_rsps.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_zero_find.sv
rtl/block_bitmap_allocator_unit.sv
verif/block_bitmap_allocator_unit_tb.sv
